>>> rtl/bsort_pkg.sv
package bsort_pkg;

  // Default store depth exponent: 64 values per batch at most.
  localparam int LOG_DEPTH_DEF = 6;

  // Item and register field widths.
  localparam int VALUE_W = 32;
  localparam int SIZE_W  = 3;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd6;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_SIZE_LOG2 = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_we;    // write the accepted item into the store
    logic cx_go;    // read a pair for compare-exchange
    logic cx_up;    // pair goes in ascending order
    logic rd_go;    // read one sorted value for output
    logic rd_last;  // that value closes the batch
  } bsort_cmd_t;

endpackage

>>> rtl/bitonic_sorter.sv
// Loads one item per cycle while in_stall is low; a batch of n = 2^L values
// then sorts in L*(L+1)/2 stages on one shared compare-exchange unit, with a
// bubble after each stage. Results leave one per cycle while out_stall is low.
// No new batch is loaded until every result has been read from the store.
// Reset is synchronous and active low: control clears, size_log2 returns to 6,
// and the value store keeps its contents (each entry is loaded before use).
module bitonic_sorter import bsort_pkg::*; #(
  parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_sorted_value,
  output logic                      out_last_of_batch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  logic [SIZE_W-1:0]    size_log2_r;
  logic                 cfg_sel;
  logic                 cfg_wr;
  logic                 out_room;
  bsort_cmd_t           cmd;
  logic [LOG_DEPTH-1:0] idx_a, idx_b;

  // Register decode: the size register is the only one.
  assign cfg_sel = (paddr[PADDR_W-1:2] == REG_SIZE_LOG2);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? PDATA_W'(size_log2_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= SIZE_RESET;
    end else if (cfg_wr) begin
      size_log2_r <= pwdata[SIZE_W-1:0];
    end
  end

  bsort_ctrl #(.LOG_DEPTH(LOG_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .size_log2 (size_log2_r),
    .cfg_clr   (cfg_wr),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_room  (out_room),
    .cmd       (cmd),
    .idx_a     (idx_a),
    .idx_b     (idx_b)
  );

  bsort_dp #(.LOG_DEPTH(LOG_DEPTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .idx_a             (idx_a),
    .idx_b             (idx_b),
    .in_value          (in_value),
    .out_room          (out_room),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sorted_value  (out_sorted_value),
    .out_last_of_batch (out_last_of_batch)
  );

endmodule

>>> rtl/bsort_ram.sv
module bsort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bsort_ctrl.sv
module bsort_ctrl import bsort_pkg::*; #(
  parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [SIZE_W-1:0]    size_log2,
  input  logic                 cfg_clr,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_room,
  output bsort_cmd_t           cmd,
  output logic [LOG_DEPTH-1:0] idx_a,
  output logic [LOG_DEPTH-1:0] idx_b
);

  localparam int KW = $clog2(LOG_DEPTH + 1);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_GAP  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [LOG_DEPTH-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0]        kl_r, kl_nxt;
  logic [KW-1:0]        s_r, s_nxt;
  logic                 done_r, done_nxt;

  logic [KW-1:0]        lg;
  logic [LOG_DEPTH-1:0] nm1;
  logic [LOG_DEPTH-1:0] low_mask;
  logic [LOG_DEPTH-1:0] pair_i;
  logic [LOG_DEPTH-1:0] pair_p;
  logic [LOG_DEPTH:0]   dir_bits;
  logic                 in_acc;

  // Batch size exponent, saturated to the store depth.
  assign lg  = (size_log2 > SIZE_W'(LOG_DEPTH)) ? KW'(LOG_DEPTH) : KW'(size_log2);
  assign nm1 = LOG_DEPTH'(((LOG_DEPTH + 1)'(1) << lg) - (LOG_DEPTH + 1)'(1));

  // Lower index of the pair: the counter with a zero inserted at bit s.
  assign low_mask = (LOG_DEPTH'(1) << s_r) - LOG_DEPTH'(1);
  assign pair_i   = ((cnt_r >> s_r) << (s_r + KW'(1))) | (cnt_r & low_mask);
  assign pair_p   = pair_i | (LOG_DEPTH'(1) << s_r);
  assign dir_bits = {1'b0, pair_i} >> kl_r;

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;

  // Sequencer: load, sort stages with a bubble between them, then unload.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    kl_nxt    = kl_r;
    s_nxt     = s_r;
    done_nxt  = done_r;
    cmd       = '0;
    idx_a     = cnt_r;
    idx_b     = pair_p;
    case (state_r)
      ST_LOAD: begin
        if (cfg_clr) begin
          cnt_nxt = '0;
        end else if (in_acc) begin
          cmd.ld_we = 1'b1;
          if (cnt_r == nm1) begin
            cnt_nxt  = '0;
            kl_nxt   = KW'(1);
            s_nxt    = '0;
            done_nxt = 1'b0;
            state_nxt = (lg == '0) ? ST_OUT : ST_SORT;
          end else begin
            cnt_nxt = cnt_r + LOG_DEPTH'(1);
          end
        end
      end
      ST_SORT: begin
        cmd.cx_go = 1'b1;
        cmd.cx_up = !dir_bits[0];
        idx_a     = pair_i;
        if (cnt_r == (nm1 >> 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_GAP;
          if (s_r == '0) begin
            if (kl_r == lg) begin
              done_nxt = 1'b1;
            end else begin
              kl_nxt = kl_r + KW'(1);
              s_nxt  = kl_r;
            end
          end else begin
            s_nxt = s_r - KW'(1);
          end
        end else begin
          cnt_nxt = cnt_r + LOG_DEPTH'(1);
        end
      end
      ST_GAP: begin
        state_nxt = done_r ? ST_OUT : ST_SORT;
        done_nxt  = 1'b0;
      end
      ST_OUT: begin
        if (out_room) begin
          cmd.rd_go   = 1'b1;
          cmd.rd_last = (cnt_r == nm1);
          if (cnt_r == nm1) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            cnt_nxt = cnt_r + LOG_DEPTH'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      kl_r    <= KW'(1);
      s_r     <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      kl_r    <= kl_nxt;
      s_r     <= s_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

>>> rtl/bsort_dp.sv
module bsort_dp import bsort_pkg::*; #(
  parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bsort_cmd_t                cmd,
  input  logic [LOG_DEPTH-1:0]      idx_a,
  input  logic [LOG_DEPTH-1:0]      idx_b,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_room,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_sorted_value,
  output logic                      out_last_of_batch
);

  // Two banks split by index parity: the two members of any pair always
  // differ in one bit, so they sit in opposite banks.
  localparam int BANK_AW    = (LOG_DEPTH > 1) ? LOG_DEPTH - 1 : 1;
  localparam int BANK_DEPTH = 1 << BANK_AW;

  logic               par_a;
  logic [BANK_AW-1:0] addr_a, addr_b;

  logic               we0, we1;
  logic [BANK_AW-1:0] waddr0, waddr1, raddr0, raddr1;
  logic [VALUE_W-1:0] wdata0, wdata1, rdata0, rdata1;

  // Compare-exchange stage registers.
  logic               cx_valid_r;
  logic               cx_par_r;
  logic               cx_up_r;
  logic [BANK_AW-1:0] cx_addr_i_r, cx_addr_p_r;

  logic signed [VALUE_W-1:0] val_i, val_p, new_i, new_p;
  logic                      swap;

  // Output read and two-entry output buffer.
  logic                      pend_r, pend_bank_r, pend_last_r;
  logic signed [VALUE_W-1:0] pend_data;
  logic                      out_valid_r, out_valid_nxt;
  logic                      skid_valid_r, skid_valid_nxt;
  logic signed [VALUE_W-1:0] out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;
  logic                      out_last_r, out_last_nxt, skid_last_r, skid_last_nxt;
  logic                      take;
  logic [1:0]                occ;

  assign par_a  = ^idx_a;
  assign addr_a = BANK_AW'(idx_a >> 1);
  assign addr_b = BANK_AW'(idx_b >> 1);

  // Read addresses: a pair reads both banks, an output read one bank.
  assign raddr0 = (cmd.cx_go && par_a) ? addr_b : addr_a;
  assign raddr1 = (cmd.cx_go && !par_a) ? addr_b : addr_a;

  // Compare the pair read last cycle and order it by direction.
  assign val_i = cx_par_r ? rdata1 : rdata0;
  assign val_p = cx_par_r ? rdata0 : rdata1;
  assign swap  = cx_up_r ? (val_i > val_p) : (val_p > val_i);
  assign new_i = swap ? val_p : val_i;
  assign new_p = swap ? val_i : val_p;

  // Write ports: write-back of a pair, or a loaded item.
  always_comb begin
    we0    = cx_valid_r || (cmd.ld_we && !par_a);
    we1    = cx_valid_r || (cmd.ld_we && par_a);
    waddr0 = addr_a;
    waddr1 = addr_a;
    wdata0 = in_value;
    wdata1 = in_value;
    if (cx_valid_r) begin
      waddr0 = cx_par_r ? cx_addr_p_r : cx_addr_i_r;
      waddr1 = cx_par_r ? cx_addr_i_r : cx_addr_p_r;
      wdata0 = cx_par_r ? new_p : new_i;
      wdata1 = cx_par_r ? new_i : new_p;
    end
  end

  bsort_ram #(.WIDTH(VALUE_W), .DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .raddr (raddr0),
    .rdata (rdata0)
  );

  bsort_ram #(.WIDTH(VALUE_W), .DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (wdata1),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    cx_par_r    <= par_a;
    cx_up_r     <= cmd.cx_up;
    cx_addr_i_r <= addr_a;
    cx_addr_p_r <= addr_b;
    pend_bank_r <= par_a;
    pend_last_r <= cmd.rd_last;
  end

  assign pend_data = pend_bank_r ? rdata1 : rdata0;
  assign take      = out_valid_r && !out_stall;

  // Room for one more read: arrivals never exceed the two entries.
  assign occ      = {1'b0, out_valid_r} + {1'b0, skid_valid_r} + {1'b0, pend_r};
  assign out_room = (occ - {1'b0, take}) < 2'd2;

  // Output buffer: the skid entry always drains ahead of a new arrival.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_last_nxt  = skid_last_r;
    if (take) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_last_nxt   = skid_last_r;
        skid_valid_nxt = pend_r;
        skid_data_nxt  = pend_data;
        skid_last_nxt  = pend_last_r;
      end else begin
        out_valid_nxt = pend_r;
        out_data_nxt  = pend_data;
        out_last_nxt  = pend_last_r;
      end
    end else if (!out_valid_r) begin
      out_valid_nxt = pend_r;
      out_data_nxt  = pend_data;
      out_last_nxt  = pend_last_r;
    end else if (pend_r) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = pend_data;
      skid_last_nxt  = pend_last_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    skid_data_r <= skid_data_nxt;
    skid_last_r <= skid_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_valid_r   <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      cx_valid_r   <= cmd.cx_go;
      pend_r       <= cmd.rd_go;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sorted_value  = out_data_r;
  assign out_last_of_batch = out_last_r;

  // A write-back never collides with a load on the write ports.
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ld_we && cx_valid_r))
    else $error("load write collides with compare-exchange write-back");

  // An output read never starts while a pair is still being written back.
  a_read_after_sort: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_go |-> !cx_valid_r)
    else $error("output read issued before the last write-back landed");

  // A returning read always finds a free buffer entry.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !(out_valid_r && skid_valid_r))
    else $error("output buffer overflow");

  // The skid entry is only occupied behind a valid output entry.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds an item while the output is empty");

endmodule

>>> tb/tb_bitonic_sorter.sv
module tb_bitonic_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  import bsort_pkg::*;

  // Register addresses: the size register and one address that maps to nothing.
  localparam logic [PADDR_W-1:0] SIZE_ADDR     = {REG_SIZE_LOG2, 2'b00};
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  // Largest batch exponent that the block accepts before it saturates.
  localparam int MAX_LOG = LOG_DEPTH_DEF;

  // Long receiver hold-off, settle time before a register write, final drain.
  localparam int HOLD_CYCLES   = 1500;
  localparam int SETTLE_CYCLES = 50;
  localparam int DRAIN_CYCLES  = 100;
  localparam int IDLE_LIMIT    = 20000;

  // Predicts the sorted batches and checks each result against the oldest one.
  class batch_checker;
    logic signed [VALUE_W-1:0] batch_store [1 << MAX_LOG];
    int unsigned loaded;
    logic [SIZE_W-1:0] size_reg;
    logic signed [VALUE_W-1:0] expected_value [$];
    bit expected_last [$];
    int errors;

    function new();
      loaded = 0;
      size_reg = SIZE_RESET;
      errors = 0;
    endfunction

    // Any write to the size register drops a partly loaded batch.
    function void write_reg(int unsigned index, logic [PDATA_W-1:0] data);
      if (index == REG_SIZE_LOG2) begin
        size_reg = data[SIZE_W-1:0];
        loaded = 0;
      end
    endfunction

    // Batch length; exponents above the store depth saturate.
    function int unsigned batch_len();
      int unsigned lg;
      lg = (size_reg > MAX_LOG) ? MAX_LOG : size_reg;
      return 1 << lg;
    endfunction

    // Bitonic network over the first n entries, one compare-exchange at a time.
    function void sort_network(int unsigned n);
      int unsigned k, j, i, p;
      logic signed [VALUE_W-1:0] lo, hi;
      bit up;
      for (k = 2; k <= n; k = k * 2) begin
        for (j = k / 2; j > 0; j = j / 2) begin
          for (i = 0; i < n; i++) begin
            p = i ^ j;
            if (p > i && p < n) begin
              lo = batch_store[i];
              hi = batch_store[p];
              up = ((i & k) == 0);
              if (up ? (lo > hi) : (hi > lo)) begin
                batch_store[i] = hi;
                batch_store[p] = lo;
              end
            end
          end
        end
      end
    endfunction

    // An accepted item goes into the store; a full batch yields its sorted values.
    function void load_value(logic signed [VALUE_W-1:0] v);
      int unsigned n;
      n = batch_len();
      batch_store[loaded % (1 << MAX_LOG)] = v;
      loaded++;
      if (loaded < n)
        return;
      sort_network(n);
      for (int unsigned i = 0; i < n; i++) begin
        expected_value.push_back(batch_store[i]);
        expected_last.push_back(i + 1 == n);
      end
      loaded = 0;
    endfunction

    function void check_sorted(logic signed [VALUE_W-1:0] v, logic last);
      logic signed [VALUE_W-1:0] want_value;
      bit want_last;
      if (expected_value.size() == 0) begin
        $error("sorted_value: no value expected, got %0d", v);
        errors++;
        return;
      end
      want_value = expected_value.pop_front();
      want_last = expected_last.pop_front();
      if (v !== want_value) begin
        $error("sorted_value: expected %0d, got %0d", want_value, v);
        errors++;
      end
      if (last !== want_last) begin
        $error("last_of_batch: expected %0d, got %0d", want_last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_value.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [VALUE_W-1:0] out_sorted_value;
  logic                      out_last_of_batch;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  batch_checker board;

  // Sender burst state and the steady mode used while the receiver holds off.
  int burst_left;
  bit steady_send;

  // Receiver stall pattern and long hold-off requests.
  int hold_requests;
  int holds_served;
  int hold_left;
  int stall_mode;
  int mode_left;
  int idle_cycles;

  bitonic_sorter uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sorted_value  (out_sorted_value),
    .out_last_of_batch (out_last_of_batch),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Random value: mostly full range, some near zero for duplicates, some extremes.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Offers one item and holds it until it is accepted; bursts end in a random gap.
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!(in_valid && !in_stall));
    board.load_value(v);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if (!steady_send) begin
        gap = $urandom_range(1, 10);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering items and waits until every expected value has come out.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write in setup and access phases; the data is taken when pready is seen.
  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(addr >> 2, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: checks accepted values and stalls on a pattern of its own.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_sorted(out_sorted_value, out_last_of_batch);
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left <= 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(8, 80);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((mode_left % 7) < 2);
      endcase
    end
  end

  // Watchdog: too long without any accepted item on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("bitonic_sorter: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase_sizes [8];
    int unsigned n;
    int unsigned batches;
    int unsigned extra;

    phase_sizes = '{7, 3, 1, 5, 2, 4, 0, 6};
    board = new();
    burst_left = 0;
    steady_send = 1'b0;
    hold_requests = 0;
    holds_served = 0;
    hold_left = 0;
    stall_mode = 0;
    mode_left = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Batches of one: every value comes straight back marked as last.
    cfg_write(SIZE_ADDR, 0);
    send_value(32'sd0);
    send_value(-32'sd1);
    send_value(32'sh8000_0000);
    send_value(32'sh7fff_ffff);
    send_value(32'sd1);
    send_value(32'sh5555_5555);
    send_value(32'shaaaa_aaaa);
    finish_phase();

    // Batches of four with the extremes and with repeated values.
    cfg_write(SIZE_ADDR, 2);
    send_value(32'sh7fff_ffff);
    send_value(32'sh8000_0000);
    send_value(-32'sd1);
    send_value(32'sd0);
    send_value(32'sd5);
    send_value(32'sd5);
    send_value(-32'sd5);
    send_value(32'sd5);
    finish_phase();

    // A size change in the middle of a batch throws the loaded values away.
    cfg_write(SIZE_ADDR, 3);
    send_value(32'sd77);
    send_value(-32'sd77);
    send_value(32'sd3);
    finish_phase();
    cfg_write(SIZE_ADDR, 1);
    send_value(32'sd10);
    send_value(-32'sd10);
    finish_phase();

    // A write to an unmapped address leaves the partial batch in place.
    send_value(32'sd100);
    finish_phase();
    cfg_write(UNMAPPED_ADDR, 0);
    send_value(-32'sd100);
    finish_phase();

    // Random phases; the first one uses the saturating size with a long hold-off.
    foreach (phase_sizes[p]) begin
      cfg_write(SIZE_ADDR, phase_sizes[p]);
      n = 1 << ((phase_sizes[p] > MAX_LOG) ? MAX_LOG : phase_sizes[p]);
      batches = (n >= 24) ? 1 : 24 / n;
      extra = (n == 1) ? 0 : $urandom_range(0, (n > 8) ? 8 : n - 1);
      if (p == 0) begin
        steady_send = 1'b1;
        hold_requests++;
      end
      repeat (batches * n + extra) send_value(pick_value());
      steady_send = 1'b0;
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("bitonic_sorter: match");
    end else begin
      $display("bitonic_sorter: mismatch");
    end
    $finish;
  end

endmodule

>>> bitonic_sorter.f
rtl/bsort_pkg.sv
rtl/bsort_ram.sv
rtl/bsort_ctrl.sv
rtl/bsort_dp.sv
rtl/bitonic_sorter.sv
tb/tb_bitonic_sorter.sv
